[sv/odor_valve_sequencer_top_defines.svh]
// Assertion macros for the odor valve sequencer.
// Each expects clk and rst_n in scope at the point of use.
`ifndef ODOR_VALVE_SEQUENCER_TOP_DEFINES_SVH
`define ODOR_VALVE_SEQUENCER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OVS_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("odor valve sequencer: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define OVS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("odor valve sequencer: next-cycle check failed");

`endif

[sv/ovs_pkg.sv]
package ovs_pkg;

  // Item opcodes.
  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_MASK   = 2'd1;
  localparam logic [1:0] OP_ENABLE = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] CFG_MIN_POKE     = 3'd0;
  localparam logic [2:0] CFG_VAC_CLOSE    = 3'd1;
  localparam logic [2:0] CFG_MIN_DELIVERY = 3'd2;
  localparam logic [2:0] CFG_MAX_DELIVERY = 3'd3;
  localparam logic [2:0] CFG_DWELL        = 3'd4;
  localparam logic [2:0] CFG_TRANSITION   = 3'd5;
  localparam logic [2:0] CFG_VAC_SETUP    = 3'd6;
  localparam logic [2:0] CFG_PURGE        = 3'd7;

  // Timing registers, all in microseconds.
  typedef struct packed {
    logic [31:0] min_poke_time;
    logic [31:0] vacuum_close_time;
    logic [31:0] min_delivery_time;
    logic [31:0] max_delivery_time;
    logic [31:0] dwell_time;
    logic [31:0] transition_time;
    logic [31:0] vacuum_setup_time;
    logic [31:0] purge_time;
  } cfg_t;

  // One input beat.
  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] now_us;
    logic        beam_level;
    logic [15:0] mask_value;
    logic        enable_value;
  } in_item_t;

  // One result beat.
  typedef struct packed {
    logic [2:0]  fsm_state;
    logic        final_valve_on;
    logic        vacuum_valve_on;
    logic [15:0] odor_lines_on;
    logic [31:0] poke_total;
    logic        poke_event;
    logic        rise_event;
    logic        fall_event;
    logic        odor_request;
  } result_t;

endpackage

[sv/ovs_in_if.sv]
interface ovs_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [31:0] now_us;
  logic        beam_level;
  logic [15:0] mask_value;
  logic        enable_value;

  modport source (output valid, opcode, now_us, beam_level, mask_value, enable_value,
                  input ready);
  modport sink (input valid, opcode, now_us, beam_level, mask_value, enable_value,
                output ready);
endinterface

[sv/ovs_out_if.sv]
interface ovs_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  fsm_state;
  logic        final_valve_on;
  logic        vacuum_valve_on;
  logic [15:0] odor_lines_on;
  logic [31:0] poke_total;
  logic        poke_event;
  logic        rise_event;
  logic        fall_event;
  logic        odor_request;

  modport source (output valid, fsm_state, final_valve_on, vacuum_valve_on, odor_lines_on,
                  poke_total, poke_event, rise_event, fall_event, odor_request,
                  input ready);
  modport sink (input valid, fsm_state, final_valve_on, vacuum_valve_on, odor_lines_on,
                poke_total, poke_event, rise_event, fall_event, odor_request,
                output ready);
endinterface

[sv/ovs_cfg.sv]
module ovs_cfg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wdata,
  output ovs_pkg::cfg_t      cfg
);

  ovs_pkg::cfg_t cfg_r;

  // Timing registers, written one at a time by index.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_poke_time     <= 32'd100000;
      cfg_r.vacuum_close_time <= 32'd100000;
      cfg_r.min_delivery_time <= 32'd500000;
      cfg_r.max_delivery_time <= 32'd2000000;
      cfg_r.dwell_time        <= 32'd1000000;
      cfg_r.transition_time   <= 32'd500000;
      cfg_r.vacuum_setup_time <= 32'd500000;
      cfg_r.purge_time        <= 32'd1000000;
    end else if (cfg_we) begin
      case (cfg_index)
        ovs_pkg::CFG_MIN_POKE:     cfg_r.min_poke_time     <= cfg_wdata;
        ovs_pkg::CFG_VAC_CLOSE:    cfg_r.vacuum_close_time <= cfg_wdata;
        ovs_pkg::CFG_MIN_DELIVERY: cfg_r.min_delivery_time <= cfg_wdata;
        ovs_pkg::CFG_MAX_DELIVERY: cfg_r.max_delivery_time <= cfg_wdata;
        ovs_pkg::CFG_DWELL:        cfg_r.dwell_time        <= cfg_wdata;
        ovs_pkg::CFG_TRANSITION:   cfg_r.transition_time   <= cfg_wdata;
        ovs_pkg::CFG_VAC_SETUP:    cfg_r.vacuum_setup_time <= cfg_wdata;
        ovs_pkg::CFG_PURGE:        cfg_r.purge_time        <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

[sv/ovs_core.sv]
module ovs_core #(
  parameter int NUM_ODOR_LINES = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  ovs_pkg::in_item_t    item,
  input  ovs_pkg::cfg_t        cfg,
  output ovs_pkg::result_t     res
);

  typedef enum logic [2:0] {
    PH_RESET    = 3'd0,
    PH_SETUP    = 3'd1,
    PH_DISPENSE = 3'd2,
    PH_DELIVER  = 3'd3,
    PH_DWELL    = 3'd4,
    PH_PRECLEAN = 3'd5,
    PH_VACUUM   = 3'd6,
    PH_PURGE    = 3'd7
  } phase_t;

  // Odor outputs that exist on this build; the rest are never driven.
  localparam logic [15:0] ValidOdorBits = (NUM_ODOR_LINES >= 16) ? 16'hFFFF :
                                          16'((32'd1 << NUM_ODOR_LINES) - 32'd1);

  phase_t      phase_r, phase_nxt;
  logic [31:0] entry_time_r, entry_time_nxt;
  logic [31:0] poke_start_r, poke_start_nxt;
  logic        raw_level_r, raw_level_nxt;
  logic        beam_broken_r, beam_broken_nxt;
  logic        poke_latched_r, poke_latched_nxt;
  logic        poke_pending_r, poke_pending_nxt;
  logic        poke_blocked_r, poke_blocked_nxt;
  logic        request_sent_r, request_sent_nxt;
  logic        disabled_r, disabled_nxt;
  logic [15:0] odor_mask_r, odor_mask_nxt;
  logic [31:0] delivery_cnt_r, delivery_cnt_nxt;
  logic        drv_final_r, drv_final_nxt;
  logic        drv_vac_r, drv_vac_nxt;
  logic [15:0] drv_odor_r, drv_odor_nxt;

  phase_t      cur_phase;
  phase_t      tgt_phase;
  logic [31:0] poke_dur;
  logic [31:0] phase_dur;
  logic        ev_poke, ev_rise, ev_fall, ev_req;

  // Next state per item: mask load, enable, or tick (poke, request, phase step).
  always_comb begin
    phase_nxt        = phase_r;
    entry_time_nxt   = entry_time_r;
    poke_start_nxt   = poke_start_r;
    raw_level_nxt    = raw_level_r;
    beam_broken_nxt  = beam_broken_r;
    poke_latched_nxt = poke_latched_r;
    poke_pending_nxt = poke_pending_r;
    poke_blocked_nxt = poke_blocked_r;
    request_sent_nxt = request_sent_r;
    disabled_nxt     = disabled_r;
    odor_mask_nxt    = odor_mask_r;
    delivery_cnt_nxt = delivery_cnt_r;
    drv_final_nxt    = drv_final_r;
    drv_vac_nxt      = drv_vac_r;
    drv_odor_nxt     = drv_odor_r;
    cur_phase        = phase_r;
    tgt_phase        = phase_r;
    poke_dur         = '0;
    phase_dur        = '0;
    ev_poke          = 1'b0;
    ev_rise          = 1'b0;
    ev_fall          = 1'b0;
    ev_req           = 1'b0;

    case (item.opcode)
      ovs_pkg::OP_MASK: begin
        odor_mask_nxt = item.mask_value;
      end
      ovs_pkg::OP_ENABLE: begin
        if (item.enable_value) begin
          disabled_nxt = 1'b0;
        end else begin
          disabled_nxt     = 1'b1;
          drv_final_nxt    = 1'b0;
          drv_vac_nxt      = 1'b0;
          drv_odor_nxt     = '0;
          phase_nxt        = PH_RESET;
          poke_pending_nxt = 1'b0;
          beam_broken_nxt  = 1'b0;
          poke_latched_nxt = 1'b0;
          poke_blocked_nxt = 1'b0;
        end
      end
      ovs_pkg::OP_TICK: begin
        if (!disabled_r) begin
          // Raw edges; a poke only starts when detection is not blocked.
          if (!item.beam_level) begin
            poke_start_nxt = item.now_us;
            if (raw_level_r) begin
              beam_broken_nxt  = 1'b0;
              poke_latched_nxt = 1'b0;
              ev_fall          = 1'b1;
            end
            raw_level_nxt = 1'b0;
          end else begin
            if (!raw_level_r) begin
              if (!poke_blocked_r) begin
                beam_broken_nxt = 1'b1;
                poke_start_nxt  = item.now_us;
              end else begin
                beam_broken_nxt = 1'b0;
              end
              ev_rise = 1'b1;
            end
            raw_level_nxt = 1'b1;
          end

          // Qualify the poke once it has been held long enough.
          poke_dur = item.now_us - poke_start_nxt;
          if (beam_broken_nxt && !poke_latched_nxt && (poke_dur >= cfg.min_poke_time)) begin
            poke_pending_nxt = 1'b1;
            poke_latched_nxt = 1'b1;
            ev_poke          = 1'b1;
          end

          // Ask for the next mask; an empty mask in dispense restarts the cycle.
          if ((odor_mask_r == '0) && !request_sent_r) begin
            if (phase_r == PH_DISPENSE) begin
              ev_req           = 1'b1;
              request_sent_nxt = 1'b1;
              cur_phase        = PH_RESET;
            end else if (phase_r == PH_PURGE) begin
              ev_req           = 1'b1;
              request_sent_nxt = 1'b1;
            end
          end

          // Phase step against the time spent in the current phase.
          tgt_phase = cur_phase;
          phase_dur = item.now_us - entry_time_r;
          case (cur_phase)
            PH_RESET: begin
              drv_final_nxt = 1'b0;
              drv_vac_nxt   = 1'b0;
              drv_odor_nxt  = '0;
              tgt_phase     = PH_SETUP;
            end
            PH_SETUP: begin
              if (odor_mask_r == '0) begin
                poke_pending_nxt = 1'b0;
              end else if (phase_dur >= cfg.vacuum_close_time) begin
                drv_odor_nxt = odor_mask_r & ValidOdorBits;
                tgt_phase    = PH_DISPENSE;
              end
            end
            PH_DISPENSE: begin
              if (poke_pending_nxt) tgt_phase = PH_DELIVER;
            end
            PH_DELIVER: begin
              if (((phase_dur >= cfg.min_delivery_time) && !poke_latched_nxt) ||
                  (phase_dur >= cfg.max_delivery_time)) begin
                tgt_phase = PH_DWELL;
              end
            end
            PH_DWELL: begin
              if (poke_pending_nxt) begin
                tgt_phase = PH_DELIVER;
              end else if (phase_dur >= cfg.dwell_time) begin
                tgt_phase = PH_PRECLEAN;
              end
            end
            PH_PRECLEAN: begin
              if (phase_dur >= cfg.transition_time) tgt_phase = PH_VACUUM;
            end
            PH_VACUUM: begin
              if (phase_dur >= cfg.vacuum_setup_time) tgt_phase = PH_PURGE;
            end
            default: begin
              if (phase_dur >= cfg.purge_time) tgt_phase = PH_SETUP;
            end
          endcase

          // Actions on entering a new phase.
          if (tgt_phase != cur_phase) begin
            entry_time_nxt = item.now_us;
            case (tgt_phase)
              PH_SETUP: begin
                drv_final_nxt = 1'b0;
                drv_vac_nxt   = 1'b0;
                drv_odor_nxt  = '0;
              end
              PH_DISPENSE: begin
                poke_blocked_nxt = 1'b0;
                request_sent_nxt = 1'b0;
              end
              PH_DELIVER: begin
                drv_final_nxt    = 1'b1;
                delivery_cnt_nxt = delivery_cnt_r + 32'd1;
                poke_blocked_nxt = 1'b1;
                poke_pending_nxt = 1'b0;
              end
              PH_DWELL: begin
                drv_final_nxt    = 1'b0;
                poke_blocked_nxt = 1'b0;
              end
              PH_PRECLEAN: begin
                poke_blocked_nxt = 1'b1;
                drv_final_nxt    = 1'b0;
              end
              PH_VACUUM: begin
                drv_odor_nxt = '0;
                drv_vac_nxt  = 1'b1;
              end
              PH_PURGE: begin
                drv_final_nxt    = 1'b1;
                odor_mask_nxt    = '0;
                request_sent_nxt = 1'b0;
              end
              default: ;
            endcase
          end
          phase_nxt = tgt_phase;
        end
      end
      default: ;
    endcase
  end

  // Result of the item, taken from the state it leaves behind.
  always_comb begin
    res.fsm_state       = phase_nxt;
    res.final_valve_on  = drv_final_nxt;
    res.vacuum_valve_on = drv_vac_nxt;
    res.odor_lines_on   = drv_odor_nxt;
    res.poke_total      = delivery_cnt_nxt;
    res.poke_event      = ev_poke;
    res.rise_event      = ev_rise;
    res.fall_event      = ev_fall;
    res.odor_request    = ev_req;
  end

  // Sequencer state, updated once per processed beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_RESET;
      entry_time_r   <= '0;
      poke_start_r   <= '0;
      raw_level_r    <= 1'b0;
      beam_broken_r  <= 1'b0;
      poke_latched_r <= 1'b0;
      poke_pending_r <= 1'b0;
      poke_blocked_r <= 1'b0;
      request_sent_r <= 1'b0;
      disabled_r     <= 1'b1;
      odor_mask_r    <= '0;
      delivery_cnt_r <= '0;
      drv_final_r    <= 1'b0;
      drv_vac_r      <= 1'b0;
      drv_odor_r     <= '0;
    end else if (adv) begin
      phase_r        <= phase_nxt;
      entry_time_r   <= entry_time_nxt;
      poke_start_r   <= poke_start_nxt;
      raw_level_r    <= raw_level_nxt;
      beam_broken_r  <= beam_broken_nxt;
      poke_latched_r <= poke_latched_nxt;
      poke_pending_r <= poke_pending_nxt;
      poke_blocked_r <= poke_blocked_nxt;
      request_sent_r <= request_sent_nxt;
      disabled_r     <= disabled_nxt;
      odor_mask_r    <= odor_mask_nxt;
      delivery_cnt_r <= delivery_cnt_nxt;
      drv_final_r    <= drv_final_nxt;
      drv_vac_r      <= drv_vac_nxt;
      drv_odor_r     <= drv_odor_nxt;
    end
  end

endmodule

[sv/odor_valve_sequencer_top.sv]
// Odor valve sequencer.
// Input channel in_ch carries one beat per event: a tick (timestamp and beam
// level), an odor mask load or an enable/disable command. Every input beat
// produces exactly one result beat on out_ch, in order, holding the phase,
// the valve drives, the delivery count and the events of that beat.
// Timing registers are to be written through cfg_we, cfg_index and cfg_wdata
// only while the block is idle; this binds the user, the block has no check.
// A beat is held in the input register, passes through the phase logic and
// its result is registered in the result register.
// Throughput: one beat per cycle while out_ch.ready stays high, set by the
// single pass through the phase logic between the input and result registers.
// A stalled receiver holds the result register; one more beat can wait in the
// input register, after which in_ch.ready falls until the result is taken.
// Reset (rst_n low, synchronous) empties both registers, loads the default
// timings, puts the sequencer in its reset phase with all valves off, and
// leaves it disabled until an enable beat arrives.
`include "odor_valve_sequencer_top_defines.svh"

module odor_valve_sequencer_top #(
  parameter int NUM_ODOR_LINES = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  ovs_in_if.sink       in_ch,
  ovs_out_if.source    out_ch,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_wdata
);

  ovs_pkg::cfg_t     cfg;
  ovs_pkg::in_item_t in_item;
  ovs_pkg::in_item_t in_item_r;
  ovs_pkg::result_t  res;
  ovs_pkg::result_t  out_res_r;
  logic              in_vld_r;
  logic              out_vld_r;
  logic              adv;
  logic              out_early_phase;
  logic              out_vacuum_phase;

  ovs_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ovs_core #(
    .NUM_ODOR_LINES (NUM_ODOR_LINES)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .item  (in_item_r),
    .cfg   (cfg),
    .res   (res)
  );

  // Pack the incoming beat.
  always_comb begin
    in_item.opcode       = in_ch.opcode;
    in_item.now_us       = in_ch.now_us;
    in_item.beam_level   = in_ch.beam_level;
    in_item.mask_value   = in_ch.mask_value;
    in_item.enable_value = in_ch.enable_value;
  end

  // The held beat is processed when the result register is free or draining.
  assign adv         = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !in_vld_r || adv;

  // Input and result registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        in_vld_r <= 1'b1;
      end else if (adv) begin
        in_vld_r <= 1'b0;
      end
      if (adv) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_item_r <= in_item;
    end
    if (adv) begin
      out_res_r <= res;
    end
  end

  // Result channel.
  assign out_ch.valid           = out_vld_r;
  assign out_ch.fsm_state       = out_res_r.fsm_state;
  assign out_ch.final_valve_on  = out_res_r.final_valve_on;
  assign out_ch.vacuum_valve_on = out_res_r.vacuum_valve_on;
  assign out_ch.odor_lines_on   = out_res_r.odor_lines_on;
  assign out_ch.poke_total      = out_res_r.poke_total;
  assign out_ch.poke_event      = out_res_r.poke_event;
  assign out_ch.rise_event      = out_res_r.rise_event;
  assign out_ch.fall_event      = out_res_r.fall_event;
  assign out_ch.odor_request    = out_res_r.odor_request;

  // Phase groups of the held result: reset to dispense, and vacuum to purge.
  assign out_early_phase  = out_res_r.fsm_state inside {3'd0, 3'd1, 3'd2};
  assign out_vacuum_phase = out_res_r.fsm_state inside {3'd6, 3'd7};

  // Checks on the pipeline and on the valve pattern of each phase.
  `OVS_ASSERT_NEXT(a_result_captured, adv, out_vld_r && (out_res_r == $past(res)))
  `OVS_ASSERT_SAME(a_ready_only_when_full, !in_ch.ready, in_vld_r && out_vld_r && !out_ch.ready)
  `OVS_ASSERT_SAME(a_final_off_early, out_vld_r && out_early_phase, !out_res_r.final_valve_on)
  `OVS_ASSERT_SAME(a_vacuum_phases, out_vld_r && out_vacuum_phase, out_res_r.odor_lines_on == '0)

endmodule
